// File: src/brnc_pkg.sv
// ----------------------------------------------------------------------------
// brnc_pkg: shared definitions for the binary row noise cleaner
// Register map, reset values, field widths and the line memory defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package brnc_pkg;

  localparam int unsigned DEF_MAX_WIDTH = 1024;
  localparam int unsigned DEF_MAX_ROWS  = 1024;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned RWID_W  = 11;
  localparam int unsigned CNT_W   = 10;
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [2:0] REG_ROW_WIDTH   = 3'd0;
  localparam logic [2:0] REG_EQUAL_LIMIT = 3'd1;
  localparam logic [2:0] REG_TRANS_LIMIT = 3'd2;
  localparam logic [2:0] REG_TOP_BAND    = 3'd3;
  localparam logic [2:0] REG_BOTTOM_BAND = 3'd4;

  localparam logic [RWID_W-1:0] RST_ROW_WIDTH   = 11'd136;
  localparam logic [IDX_W-1:0]  RST_EQUAL_LIMIT = 10'd20;
  localparam logic [IDX_W-1:0]  RST_TRANS_LIMIT = 10'd8;
  localparam logic [IDX_W-1:0]  RST_TOP_BAND    = 10'd3;
  localparam logic [IDX_W-1:0]  RST_BOTTOM_BAND = 10'd32;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             cleared;
  } brnc_emit_t;

endpackage

`default_nettype wire

// File: src/binary_row_noise_cleaner_unit.sv
// Output beats pass the read stage and the output register. Throughput: one beat
// per cycle unless the output stalls; the line memory read and write share a cycle.
// Each row comes out one row late, paced by the next row or by flush beats.
// Reset clears the counters, the held row state and the pipeline valids and
// loads the register defaults; the line memory is not cleared.
// ----------------------------------------------------------------------------
// binary_row_noise_cleaner_unit: row noise filter for binarized images
// Counts transitions and equal pairs per row, judges each row at its end and
// replays the previous row from a line memory, zeroed when it was cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_row_noise_cleaner_unit
  import brnc_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int unsigned MAX_ROWS  = DEF_MAX_ROWS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // APB configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  // Input stream
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [7:0]            s_axis_tdata,  // [7:0] pixel_in
  input  wire logic [1:0]            s_axis_tuser,  // [0] kind, [1] frame_start
  // Output stream
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic      [31:0]           m_axis_tdata,  // [7:0] pixel_out, [17:8] out_row,
                                                    // [27:18] out_col, [31:28] zero
  output logic      [0:0]            m_axis_tuser   // [0] row_cleared
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_ROWS);

  // Configuration registers
  logic [RWID_W-1:0] row_width_q;
  logic [IDX_W-1:0]  equal_limit_q, trans_limit_q, top_band_q, bottom_band_q;
  logic              cfg_wr;
  logic [2:0]        cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q   <= RST_ROW_WIDTH;
      equal_limit_q <= RST_EQUAL_LIMIT;
      trans_limit_q <= RST_TRANS_LIMIT;
      top_band_q    <= RST_TOP_BAND;
      bottom_band_q <= RST_BOTTOM_BAND;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ROW_WIDTH:   row_width_q   <= pwdata[RWID_W-1:0];
        REG_EQUAL_LIMIT: equal_limit_q <= pwdata[IDX_W-1:0];
        REG_TRANS_LIMIT: trans_limit_q <= pwdata[IDX_W-1:0];
        REG_TOP_BAND:    top_band_q    <= pwdata[IDX_W-1:0];
        REG_BOTTOM_BAND: bottom_band_q <= pwdata[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ROW_WIDTH:   prdata = APB_DATA_W'(row_width_q);
      REG_EQUAL_LIMIT: prdata = APB_DATA_W'(equal_limit_q);
      REG_TRANS_LIMIT: prdata = APB_DATA_W'(trans_limit_q);
      REG_TOP_BAND:    prdata = APB_DATA_W'(top_band_q);
      REG_BOTTOM_BAND: prdata = APB_DATA_W'(bottom_band_q);
      default:         prdata = '0;
    endcase
  end

  // Last column index of a row, with the width clamped to the legal range
  logic [CW-1:0] last_col;

  always_comb begin
    if (32'(row_width_q) < 32'd2) begin
      last_col = CW'(1);
    end else if (32'(row_width_q) > 32'(MAX_WIDTH)) begin
      last_col = CW'(MAX_WIDTH - 1);
    end else begin
      last_col = CW'(row_width_q - 11'd1);
    end
  end

  // Row statistics and held row state
  logic [CW-1:0]    col_q, col_d, col_e;
  logic [RW-1:0]    row_q, row_d, row_e, row_prev, row_next;
  logic [PIX_W-1:0] prev_q, prev_d;
  logic [CNT_W-1:0] trans_q, trans_d, trans_new;
  logic [CNT_W-1:0] equal_q, equal_d, equal_new;
  logic             held_q, held_d, held_e;
  logic             clr_q, clr_d;
  logic             in_band, border, row_clear;

  logic             accept, advance, emit, mem_wr;
  logic             in_kind, in_fs;
  logic [PIX_W-1:0] in_pix;
  brnc_emit_t       emit_meta;

  assign in_kind = s_axis_tuser[0];
  assign in_fs   = s_axis_tuser[1];
  assign in_pix  = s_axis_tdata[PIX_W-1:0];

  assign row_prev = (row_q == '0) ? RW'(MAX_ROWS - 1) : row_q - RW'(1);
  assign row_next = (row_e == RW'(MAX_ROWS - 1)) ? '0 : row_e + RW'(1);

  assign col_e  = in_fs ? '0 : col_q;
  assign row_e  = in_fs ? '0 : row_q;
  assign held_e = in_fs ? 1'b0 : held_q;

  always_comb begin
    trans_new = in_fs ? '0 : trans_q;
    equal_new = in_fs ? '0 : equal_q;
    if (col_e != '0) begin
      if (in_pix != (in_fs ? '0 : prev_q)) begin
        if (trans_new != COUNT_MAX) trans_new = trans_new + CNT_W'(1);
      end else begin
        if (equal_new != COUNT_MAX) equal_new = equal_new + CNT_W'(1);
      end
    end
  end

  assign in_band   = (32'(row_e) < 32'(top_band_q)) || (32'(row_e) > 32'(bottom_band_q));
  assign border    = equal_new > equal_limit_q;
  assign row_clear = (trans_new <= trans_limit_q) || (border && in_band);

  assign emit_meta.row     = IDX_W'(row_prev);
  assign emit_meta.col     = IDX_W'(col_q);
  assign emit_meta.cleared = clr_q;

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    prev_d  = prev_q;
    trans_d = trans_q;
    equal_d = equal_q;
    held_d  = held_q;
    clr_d   = clr_q;
    emit    = 1'b0;
    mem_wr  = 1'b0;
    if (in_kind) begin
      if (held_q) begin
        emit = 1'b1;
        if (col_q >= last_col) begin
          held_d  = 1'b0;
          clr_d   = 1'b0;
          col_d   = '0;
          prev_d  = '0;
          trans_d = '0;
          equal_d = '0;
        end else begin
          col_d = col_q + CW'(1);
        end
      end
    end else begin
      emit   = held_e;
      mem_wr = 1'b1;
      if (col_e >= last_col) begin
        clr_d   = row_clear;
        held_d  = 1'b1;
        row_d   = row_next;
        col_d   = '0;
        prev_d  = '0;
        trans_d = '0;
        equal_d = '0;
      end else begin
        col_d   = col_e + CW'(1);
        row_d   = row_e;
        prev_d  = in_pix;
        trans_d = trans_new;
        equal_d = equal_new;
        held_d  = held_e;
        clr_d   = in_fs ? 1'b0 : clr_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      prev_q  <= '0;
      trans_q <= '0;
      equal_q <= '0;
      held_q  <= 1'b0;
      clr_q   <= 1'b0;
    end else if (accept) begin
      col_q   <= col_d;
      row_q   <= row_d;
      prev_q  <= prev_d;
      trans_q <= trans_d;
      equal_q <= equal_d;
      held_q  <= held_d;
      clr_q   <= clr_d;
    end
  end

  // Line memory
  logic [PIX_W-1:0] mem_rd_data;

  brnc_line_mem #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (PIX_W)
  ) u_line_mem (
    .clk_i     (clk_i),
    .wr_en_i   (accept & mem_wr),
    .wr_addr_i (col_e),
    .wr_data_i (in_pix),
    .rd_en_i   (accept & emit),
    .rd_addr_i (col_q),
    .rd_data_o (mem_rd_data)
  );

  // Read stage and output register
  logic       s1_valid_q;
  brnc_emit_t s1_meta_q;
  logic       out_valid_q;
  logic [PIX_W-1:0] out_pix_q;
  brnc_emit_t out_meta_q;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= emit;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_meta_q <= emit_meta;
    end
    if (advance && s1_valid_q) begin
      out_meta_q <= s1_meta_q;
      out_pix_q  <= s1_meta_q.cleared ? '0 : mem_rd_data;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_meta_q.col, out_meta_q.row, out_pix_q};
  assign m_axis_tuser  = out_meta_q.cleared;

  // Assertions
  a_cleared_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[7:0] == '0)
    else $error("cleared row beat carries a nonzero pixel");

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while the read stage is blocked");

  a_flush_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_kind && !held_q |=> !s1_valid_q)
    else $error("flush beat without a held row produced a result");

  a_frame_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !in_kind && in_fs |=> !s1_valid_q && row_q == '0)
    else $error("frame start pixel produced a result or kept the row index");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(col_q) < 32'(MAX_WIDTH))
    else $error("column counter out of range");

endmodule

`default_nettype wire

// File: src/brnc_line_mem.sv
// ----------------------------------------------------------------------------
// brnc_line_mem: single row line memory
// One write port and one read port with registered read data; a read and a
// write to the same address in one cycle return the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module brnc_line_mem
  import brnc_pkg::*;
#(
  parameter int unsigned DEPTH  = DEF_MAX_WIDTH,
  parameter int unsigned DATA_W = PIX_W,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              wr_en_i,
  input  wire logic [AW-1:0]     wr_addr_i,
  input  wire logic [DATA_W-1:0] wr_data_i,
  input  wire logic              rd_en_i,
  input  wire logic [AW-1:0]     rd_addr_i,
  output logic      [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire
